// ===== rtl/pst_pkg.sv =====
`default_nettype none

package pst_pkg;

    localparam int SEQ_W = 10;
    localparam int SEQ_SPACE_DEFAULT = 1024;

    // Reciprocal used to reduce a sequence number modulo the sequence space.
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W = 20;
    localparam int PROD_W = SEQ_W + RECIP_W;
    localparam int REM_W = 17;

    typedef enum logic [1:0] {
        ST_IN_ORDER     = 2'd0,
        ST_LOSS         = 2'd1,
        ST_OUT_OF_ORDER = 2'd2,
        ST_DUPLICATE    = 2'd3
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/pst_if.sv =====
`default_nettype none

interface pst_in_if;
    logic                          valid;
    logic                          ready;
    logic [pst_pkg::SEQ_W-1:0]     seq_number;

    modport source (output valid, output seq_number, input ready);
    modport sink   (input valid, input seq_number, output ready);
endinterface

interface pst_out_if;
    logic                          valid;
    logic                          ready;
    logic [pst_pkg::SEQ_W-1:0]     seq_echo;
    pst_pkg::status_t              status;
    logic [pst_pkg::SEQ_W-1:0]     gap_first;
    logic [pst_pkg::SEQ_W-1:0]     gap_last;

    modport source (output valid, output seq_echo, output status, output gap_first,
                    output gap_last, input ready);
    modport sink   (input valid, input seq_echo, input status, input gap_first,
                    input gap_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/packet_sequence_tracker_top.sv =====
`default_nettype none

// Channel   Role   Word
// seq_in    sink   seq_number
// result    source seq_echo, status, gap_first, gap_last
//
// A word is taken on seq_in in S_IDLE; S_MUL and S_MOD then reduce it to a
// bitmap index, S_RD does the bitmap read and S_UPD does classification and
// write-back on the single bitmap port. After reset the bitmap is cleared,
// one entry per cycle, before seq_in becomes ready.
// A stalled result holds in the output register; the next word is still
// taken and waits at write-back until the result register is free.

module packet_sequence_tracker_top #(
    parameter int SEQ_SPACE = pst_pkg::SEQ_SPACE_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pst_in_if.sink     seq_in,
    pst_out_if.source  result
);

    localparam int SEQ_W = pst_pkg::SEQ_W;
    localparam int IDX_W = $clog2(SEQ_SPACE);
    localparam int PROD_W = pst_pkg::PROD_W;
    localparam int REM_W = pst_pkg::REM_W;
    localparam int RECIP_I = (1 << pst_pkg::RECIP_SHIFT) / SEQ_SPACE;
    localparam logic [pst_pkg::RECIP_W-1:0] RECIP = pst_pkg::RECIP_W'(RECIP_I);
    localparam logic [REM_W-1:0] SPACE_C = REM_W'(SEQ_SPACE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEQ_SPACE - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_MOD,
        S_RD,
        S_UPD
    } state_t;

    state_t                state_reg;
    logic [IDX_W-1:0]      clr_reg;
    logic [SEQ_W-1:0]      seq_reg;
    logic [SEQ_W-1:0]      quot_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [SEQ_W-1:0]      highest_reg;
    logic                  any_seen_reg;
    logic                  rd_data_reg;

    logic                  result_valid_reg;
    logic [SEQ_W-1:0]      seq_echo_reg;
    pst_pkg::status_t      status_reg;
    logic [SEQ_W-1:0]      gap_first_reg;
    logic [SEQ_W-1:0]      gap_last_reg;

    logic                  seen_mem [SEQ_SPACE];

    logic [PROD_W-1:0]     recip_prod;
    logic [REM_W+SEQ_W-1:0] back_prod;
    logic [REM_W-1:0]      rem_raw;
    logic [REM_W-1:0]      rem_fix;

    logic [SEQ_W:0]        expected;
    pst_pkg::status_t      status_next;
    logic [SEQ_W-1:0]      gap_first_next;
    logic [SEQ_W-1:0]      gap_last_next;
    logic                  raise;
    logic                  out_free;
    logic                  upd_fire;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic                  mem_wdata;

    // The estimated quotient is at most one below the true one, so the
    // remainder needs a single correction.
    assign recip_prod = PROD_W'(seq_reg) * PROD_W'(RECIP);
    assign back_prod = (REM_W+SEQ_W)'(quot_reg) * (REM_W+SEQ_W)'(SPACE_C);
    assign rem_raw = REM_W'(seq_reg) - back_prod[REM_W-1:0];
    assign rem_fix = (rem_raw >= SPACE_C) ? (rem_raw - SPACE_C) : rem_raw;

    always_comb
    begin
        expected = any_seen_reg ? ({1'b0, highest_reg} + (SEQ_W+1)'(1)) : '0;
        gap_first_next = '0;
        gap_last_next = '0;
        if (rd_data_reg)
        begin
            status_next = pst_pkg::ST_DUPLICATE;
        end
        else if ({1'b0, seq_reg} == expected)
        begin
            status_next = pst_pkg::ST_IN_ORDER;
        end
        else if ({1'b0, seq_reg} > expected)
        begin
            status_next = pst_pkg::ST_LOSS;
            gap_first_next = expected[SEQ_W-1:0];
            gap_last_next = seq_reg - SEQ_W'(1);
        end
        else
        begin
            status_next = pst_pkg::ST_OUT_OF_ORDER;
        end
    end

    assign raise = !any_seen_reg || (seq_reg > highest_reg);
    assign out_free = !result_valid_reg || result.ready;
    assign upd_fire = (state_reg == S_UPD) && out_free;

    assign mem_we = (state_reg == S_CLEAR) || (upd_fire && !rd_data_reg);
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_reg : idx_reg;
    assign mem_wdata = (state_reg != S_CLEAR);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seen_mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == S_RD)
        begin
            rd_data_reg <= seen_mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            seq_reg <= '0;
            quot_reg <= '0;
            idx_reg <= '0;
            highest_reg <= '0;
            any_seen_reg <= 1'b0;
            result_valid_reg <= 1'b0;
            seq_echo_reg <= '0;
            status_reg <= pst_pkg::ST_IN_ORDER;
            gap_first_reg <= '0;
            gap_last_reg <= '0;
        end
        else
        begin
            if (upd_fire)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + IDX_W'(1);
                    if (clr_reg == LAST_IDX)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (seq_in.valid)
                    begin
                        seq_reg <= seq_in.seq_number;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    quot_reg <= recip_prod[PROD_W-1 -: SEQ_W];
                    state_reg <= S_MOD;
                end
                S_MOD:
                begin
                    idx_reg <= rem_fix[IDX_W-1:0];
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (out_free)
                    begin
                        seq_echo_reg <= seq_reg;
                        status_reg <= status_next;
                        gap_first_reg <= gap_first_next;
                        gap_last_reg <= gap_last_next;
                        if (!rd_data_reg)
                        begin
                            any_seen_reg <= 1'b1;
                            if (raise)
                            begin
                                highest_reg <= seq_reg;
                            end
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign seq_in.ready = (state_reg == S_IDLE);
    assign result.valid = result_valid_reg;
    assign result.seq_echo = seq_echo_reg;
    assign result.status = status_reg;
    assign result.gap_first = gap_first_reg;
    assign result.gap_last = gap_last_reg;

    a_any_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(any_seen_reg))
        else $error("any_seen cleared without reset");

    a_highest_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        any_seen_reg |=> (highest_reg >= $past(highest_reg)))
        else $error("highest sequence number decreased");

    a_duplicate_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_fire && rd_data_reg) |=> ($stable(highest_reg) && $stable(any_seen_reg)))
        else $error("duplicate changed tracker state");

    a_gap_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (status_reg == pst_pkg::ST_LOSS))
            |-> (gap_first_reg <= gap_last_reg))
        else $error("loss gap range inverted");

endmodule

`default_nettype wire
